// ===== hw/rtl/cpr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the CORDIC turn table for the phase-to-RGB pipeline.
package cpr_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int SQ_W         = 2 * SAMPLE_WIDTH;
    localparam int PRESHIFT     = 40 - SAMPLE_WIDTH;
    localparam int CORDIC_W     = 43;
    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = SAMPLE_WIDTH;
    localparam int CELLS        = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
    localparam int STAGE_W      = $clog2(CELLS);
    localparam int BACK_STAGES  = 3;
    localparam int ANGLE_W      = 32;
    localparam int SCALE_W      = 16;
    localparam int COLOUR_W     = 17;
    localparam int FRAC_W       = 16;
    localparam int CHAN_W       = 8;

    localparam logic [SCALE_W-1:0]  SCALE_RESET = 16'd2048;
    localparam logic [ANGLE_W-1:0]  HALF_TURN   = 32'h8000_0000;
    localparam logic [COLOUR_W-1:0] UNIT_Q16    = 17'h1_0000;

    typedef enum logic [2:0] {
        SECT_RED_YEL,
        SECT_YEL_GRN,
        SECT_GRN_CYN,
        SECT_CYN_BLU,
        SECT_BLU_MAG,
        SECT_MAG_RED
    } t_sector;

    // Item state carried along the cell row
    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [ANGLE_W-1:0]         ang;
        logic [SQ_W-1:0]            rem;
        logic [SQ_W-1:0]            root;
    } t_cell_data;

    // atan(2^-i) in turns, unsigned Q0.32
    function automatic logic [ANGLE_W-1:0] turn_of(input logic [STAGE_W-1:0] idx);
        logic [ANGLE_W-1:0] t;
        case (idx)
            0:       t = 32'h2000_0000;
            1:       t = 32'h12E4_051D;
            2:       t = 32'h09FB_385B;
            3:       t = 32'h0511_11D4;
            4:       t = 32'h028B_0D43;
            5:       t = 32'h0145_D7E1;
            6:       t = 32'h00A2_F61E;
            7:       t = 32'h0051_7C55;
            8:       t = 32'h0028_BE53;
            9:       t = 32'h0014_5F2E;
            10:      t = 32'h000A_2F98;
            11:      t = 32'h0005_17CC;
            12:      t = 32'h0002_8BE6;
            13:      t = 32'h0001_45F3;
            14:      t = 32'h0000_A2F9;
            15:      t = 32'h0000_517C;
            16:      t = 32'h0000_28BE;
            17:      t = 32'h0000_145F;
            18:      t = 32'h0000_0A2F;
            19:      t = 32'h0000_0517;
            20:      t = 32'h0000_028B;
            21:      t = 32'h0000_0145;
            22:      t = 32'h0000_00A2;
            23:      t = 32'h0000_0051;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/complex_phase_to_rgb.sv =====
`timescale 1ns / 1ps
// Top level: complex sample in, domain-colouring RGB pixel out.
// One item per clock is accepted and one pixel per clock is delivered while the output is not
// stalled. It has one front stage, a row of 24 cells (each doing one CORDIC vectoring step for
// the phase, the first 16 also one square-root digit for the magnitude), then three back stages
// for hue sector and brightness, colour products and channel scaling. Every stage holds its item
// while the next one is full, so empty slots close up and the input keeps flowing while a pixel
// waits at the output. The brightness gain register may be written at any time the block is idle.
module complex_phase_to_rgb (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [cpr_pkg::SAMPLE_WIDTH-1:0] i_real_part,
    input  logic signed [cpr_pkg::SAMPLE_WIDTH-1:0] i_imag_part,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [cpr_pkg::CHAN_W-1:0]              o_red,
    output logic [cpr_pkg::CHAN_W-1:0]              o_green,
    output logic [cpr_pkg::CHAN_W-1:0]              o_blue,
    input  logic                                    i_cfg_wr_en,
    input  logic [cpr_pkg::SCALE_W-1:0]             i_cfg_wr_data
);
    import cpr_pkg::*;

    localparam int NST = CELLS + 1 + BACK_STAGES;

    logic [SCALE_W-1:0]  r_magnitude_scale;
    logic [NST-1:0]      v;
    logic [NST-1:0]      en;
    t_cell_data          d [CELLS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magnitude_scale <= SCALE_RESET;
        end else if (i_cfg_wr_en) begin
            r_magnitude_scale <= i_cfg_wr_data;
        end
    end

    // A stage loads when it is empty or its successor loads too
    assign en[NST-1] = !v[NST-1] || i_out_ready;
    for (genvar k = 0; k < NST - 1; k++) begin : g_en
        assign en[k] = !v[k] || en[k+1];
    end

    cpr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (en[0]),
        .i_valid (i_in_valid),
        .i_re    (i_real_part),
        .i_im    (i_imag_part),
        .o_valid (v[0]),
        .o_data  (d[0])
    );

    for (genvar c = 0; c < CELLS; c++) begin : g_cell
        cpr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (STAGE_W'(c)),
            .i_load  (en[c+1]),
            .i_valid (v[c]),
            .i_data  (d[c]),
            .o_valid (v[c+1]),
            .o_data  (d[c+1])
        );
    end

    cpr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (en[NST-1:CELLS+1]),
        .i_valid (v[CELLS]),
        .i_data  (d[CELLS]),
        .i_scale (r_magnitude_scale),
        .o_valid (v[NST-1:CELLS+1]),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    assign o_in_ready  = en[0];
    assign o_out_valid = v[NST-1];

`ifndef ASSERT_OFF
    // The input may only stall when the output is held up
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without an output stall");

    // An accepted item lands in the front stage
    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> v[0])
        else $error("accepted item lost at the front stage");

    // Every hue sector has one dark primary
    a_one_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_red == '0 || o_green == '0 || o_blue == '0))
        else $error("pixel has no dark channel");
`endif

endmodule

// ===== hw/rtl/cpr_front.sv =====
`timescale 1ns / 1ps
// Front stage: sign handling and prescale for CORDIC, sum of squares for the root.
module cpr_front (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  logic                                    i_valid,
    input  logic signed [cpr_pkg::SAMPLE_WIDTH-1:0] i_re,
    input  logic signed [cpr_pkg::SAMPLE_WIDTH-1:0] i_im,
    output logic                                    o_valid,
    output cpr_pkg::t_cell_data                     o_data
);
    import cpr_pkg::*;

    logic                         r_valid;
    t_cell_data                   r_data;
    t_cell_data                   n_data;
    logic signed [CORDIC_W-1:0]   x_ext;
    logic signed [CORDIC_W-1:0]   y_ext;
    logic signed [CORDIC_W-1:0]   x0;
    logic signed [CORDIC_W-1:0]   y0;
    logic signed [SQ_W-1:0]       sq_re;
    logic signed [SQ_W-1:0]       sq_im;

    always_comb begin
        x_ext = {{(CORDIC_W - SAMPLE_WIDTH){i_re[SAMPLE_WIDTH-1]}}, i_re};
        y_ext = {{(CORDIC_W - SAMPLE_WIDTH){i_im[SAMPLE_WIDTH-1]}}, i_im};
        x0    = x_ext <<< PRESHIFT;
        y0    = y_ext <<< PRESHIFT;
        sq_re = SQ_W'(i_re) * SQ_W'(i_re);
        sq_im = SQ_W'(i_im) * SQ_W'(i_im);
        // Fold the left half-plane onto the right one and start half a turn on
        if (i_re[SAMPLE_WIDTH-1]) begin
            n_data.x   = -x0;
            n_data.y   = -y0;
            n_data.ang = HALF_TURN;
        end else begin
            n_data.x   = x0;
            n_data.y   = y0;
            n_data.ang = '0;
        end
        n_data.rem  = $unsigned(sq_re) + $unsigned(sq_im);
        n_data.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/cpr_cell.sv =====
`timescale 1ns / 1ps
// One cell of the row: a CORDIC vectoring step and, for stages below SQRT_STEPS, a square-root digit step.
module cpr_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [cpr_pkg::STAGE_W-1:0]  i_stage,
    input  logic                         i_load,
    input  logic                         i_valid,
    input  cpr_pkg::t_cell_data          i_data,
    output logic                         o_valid,
    output cpr_pkg::t_cell_data          o_data
);
    import cpr_pkg::*;

    logic                       r_valid;
    t_cell_data                 r_data;
    t_cell_data                 n_data;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic [SQ_W-1:0]            sbit;
    logic [SQ_W:0]              trial;

    always_comb begin
        n_data = i_data;
        xs     = i_data.x >>> i_stage;
        ys     = i_data.y >>> i_stage;
        sbit   = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - int'(i_stage)));
        trial  = {1'b0, i_data.root} + {1'b0, sbit};
        if (int'(i_stage) < CORDIC_STEPS) begin
            // Rotate towards the x axis using the old x and y
            if (!i_data.y[CORDIC_W-1]) begin
                n_data.x   = i_data.x + ys;
                n_data.y   = i_data.y - xs;
                n_data.ang = i_data.ang + turn_of(i_stage);
            end else begin
                n_data.x   = i_data.x - ys;
                n_data.y   = i_data.y + xs;
                n_data.ang = i_data.ang - turn_of(i_stage);
            end
        end
        if (int'(i_stage) < SQRT_STEPS) begin
            if ({1'b0, i_data.rem} >= trial) begin
                n_data.rem  = i_data.rem - trial[SQ_W-1:0];
                n_data.root = (i_data.root >> 1) + sbit;
            end else begin
                n_data.root = i_data.root >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/cpr_back.sv =====
`timescale 1ns / 1ps
// Back stages: hue sector and ramp, brightness, colour products and channel scaling.
module cpr_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [cpr_pkg::BACK_STAGES-1:0]      i_load,
    input  logic                                 i_valid,
    input  cpr_pkg::t_cell_data                  i_data,
    input  logic [cpr_pkg::SCALE_W-1:0]          i_scale,
    output logic [cpr_pkg::BACK_STAGES-1:0]      o_valid,
    output logic [cpr_pkg::CHAN_W-1:0]           o_red,
    output logic [cpr_pkg::CHAN_W-1:0]           o_green,
    output logic [cpr_pkg::CHAN_W-1:0]           o_blue
);
    import cpr_pkg::*;

    localparam int PROD_W  = SAMPLE_WIDTH + SCALE_W;
    localparam int BFULL_W = PROD_W - (SAMPLE_WIDTH - 8);
    localparam int H6_W    = ANGLE_W + 3;
    localparam int P_W     = 2 * COLOUR_W;
    localparam int T_W     = P_W + 8;

    logic [BACK_STAGES-1:0] r_valid;

    // stage A
    logic [ANGLE_W-1:0]     hue;
    logic [H6_W-1:0]        h6;
    logic [PROD_W-1:0]      prod;
    logic [BFULL_W-1:0]     bfull;
    t_sector                r_a_sector;
    logic [FRAC_W-1:0]      r_a_f;
    logic [COLOUR_W-1:0]    r_a_b;

    // stage B
    logic [COLOUR_W-1:0]    g;
    logic [COLOUR_W-1:0]    c_r;
    logic [COLOUR_W-1:0]    c_g;
    logic [COLOUR_W-1:0]    c_b;
    logic [P_W-1:0]         r_b_pr;
    logic [P_W-1:0]         r_b_pg;
    logic [P_W-1:0]         r_b_pb;

    // stage C
    logic [T_W-1:0]         t_r;
    logic [T_W-1:0]         t_g;
    logic [T_W-1:0]         t_b;
    logic [CHAN_W-1:0]      r_red;
    logic [CHAN_W-1:0]      r_green;
    logic [CHAN_W-1:0]      r_blue;

    always_comb begin
        hue   = i_data.ang + HALF_TURN;
        h6    = ({3'b000, hue} << 2) + ({3'b000, hue} << 1);
        prod  = PROD_W'(i_data.root[SAMPLE_WIDTH-1:0]) * PROD_W'(i_scale);
        bfull = prod[PROD_W-1:SAMPLE_WIDTH-8];
    end

    always_comb begin
        g = UNIT_Q16 - {1'b0, r_a_f};
        case (r_a_sector)
            SECT_YEL_GRN: begin c_r = g;        c_g = UNIT_Q16;      c_b = '0;            end
            SECT_GRN_CYN: begin c_r = '0;       c_g = UNIT_Q16;      c_b = {1'b0, r_a_f}; end
            SECT_CYN_BLU: begin c_r = '0;       c_g = g;             c_b = UNIT_Q16;      end
            SECT_BLU_MAG: begin c_r = {1'b0, r_a_f}; c_g = '0;       c_b = UNIT_Q16;      end
            SECT_MAG_RED: begin c_r = UNIT_Q16; c_g = '0;            c_b = g;             end
            default:      begin c_r = UNIT_Q16; c_g = {1'b0, r_a_f}; c_b = '0;            end
        endcase
    end

    // 255 * p as (p << 8) - p
    always_comb begin
        t_r = {r_b_pr, 8'b0} - {8'b0, r_b_pr};
        t_g = {r_b_pg, 8'b0} - {8'b0, r_b_pg};
        t_b = {r_b_pb, 8'b0} - {8'b0, r_b_pb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_load[0]) r_valid[0] <= i_valid;
            if (i_load[1]) r_valid[1] <= r_valid[0];
            if (i_load[2]) r_valid[2] <= r_valid[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_a_sector <= t_sector'(h6[H6_W-1:ANGLE_W]);
            r_a_f      <= h6[ANGLE_W-1:ANGLE_W-FRAC_W];
            // Saturate brightness at one
            if (bfull > BFULL_W'(UNIT_Q16)) begin
                r_a_b <= UNIT_Q16;
            end else begin
                r_a_b <= bfull[COLOUR_W-1:0];
            end
        end
        if (i_load[1]) begin
            r_b_pr <= P_W'(c_r) * P_W'(r_a_b);
            r_b_pg <= P_W'(c_g) * P_W'(r_a_b);
            r_b_pb <= P_W'(c_b) * P_W'(r_a_b);
        end
        if (i_load[2]) begin
            r_red   <= t_r[39:32];
            r_green <= t_g[39:32];
            r_blue  <= t_b[39:32];
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// ===== bench/complex_phase_to_rgb_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for complex_phase_to_rgb: queued samples, hue-wheel predictor, pixel check.
module complex_phase_to_rgb_tb;
    import cpr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AT = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    // atan(2^-i) in turns, Q0.32
    localparam logic [ANGLE_W-1:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
        32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
    };

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
    } t_sample;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic signed [SAMPLE_WIDTH-1:0] i_real_part = '0;
    logic signed [SAMPLE_WIDTH-1:0] i_imag_part = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [CHAN_W-1:0]              o_red;
    logic [CHAN_W-1:0]              o_green;
    logic [CHAN_W-1:0]              o_blue;
    logic                           i_cfg_wr_en = 1'b0;
    logic [SCALE_W-1:0]             i_cfg_wr_data = '0;

    t_sample            samples_to_send[$];
    t_pixel             pixels_due[$];
    logic [SCALE_W-1:0] gain_now = SCALE_RESET;
    bit                 calm = 1'b0;
    int                 mismatches = 0;
    int                 pixels_checked = 0;
    int                 hold_left = 0;
    bit                 hold_done = 1'b0;
    int                 quiet_cycles = 0;

    complex_phase_to_rgb dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_real_part   (i_real_part),
        .i_imag_part   (i_imag_part),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [CHAN_W-1:0] scale_channel(longint colour, longint bright);
        longint prod;
        prod = (longint'(255) * colour * bright) >>> 32;
        return prod[CHAN_W-1:0];
    endfunction

    function automatic t_pixel colour_of_sample(logic signed [SAMPLE_WIDTH-1:0] re,
                                                logic signed [SAMPLE_WIDTH-1:0] im,
                                                logic [SCALE_W-1:0] gain);
        longint             x, y, xs, ys, sq, mag, bright, f, g, cr, cg, cb;
        logic [ANGLE_W-1:0] ang, hue;
        logic [63:0]        h6;
        t_sector            sect;
        t_pixel             px;
        x = longint'(re) * (longint'(1) << PRESHIFT);
        y = longint'(im) * (longint'(1) << PRESHIFT);
        ang = '0;
        // left half-plane: rotate by a half turn first
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = HALF_TURN;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                ang = ang + ATAN_TURNS[i];
            end else begin
                x = x - ys;
                y = y + xs;
                ang = ang - ATAN_TURNS[i];
            end
        end
        hue = ang + HALF_TURN;
        h6 = 64'(hue) * 64'd6;
        sect = t_sector'(h6[34:32]);
        f = longint'(h6[31:16]);
        g = 65536 - f;
        sq = longint'(re) * longint'(re) + longint'(im) * longint'(im);
        mag = 0;
        for (int k = 16; k >= 0; k--) begin
            if ((mag | (longint'(1) << k)) * (mag | (longint'(1) << k)) <= sq)
                mag = mag | (longint'(1) << k);
        end
        bright = (mag * longint'(gain)) >>> (SAMPLE_WIDTH - 8);
        if (bright > 65536)
            bright = 65536;
        case (sect)
            SECT_YEL_GRN: begin cr = g;     cg = 65536; cb = 0;     end
            SECT_GRN_CYN: begin cr = 0;     cg = 65536; cb = f;     end
            SECT_CYN_BLU: begin cr = 0;     cg = g;     cb = 65536; end
            SECT_BLU_MAG: begin cr = f;     cg = 0;     cb = 65536; end
            SECT_MAG_RED: begin cr = 65536; cg = 0;     cb = g;     end
            default:      begin cr = 65536; cg = f;     cb = 0;     end
        endcase
        px.red = scale_channel(cr, bright);
        px.green = scale_channel(cg, bright);
        px.blue = scale_channel(cb, bright);
        return px;
    endfunction

    // Driver: present queued samples, hold each until taken
    always @(posedge i_clk) begin
        t_sample s;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                pixels_due.push_back(colour_of_sample(i_real_part, i_imag_part, gain_now));
            if (!i_in_valid || o_in_ready) begin
                if (samples_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 19)) begin
                    s = samples_to_send.pop_front();
                    i_real_part <= s.re;
                    i_imag_part <= s.im;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each delivered pixel and pace the output side
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pixels_due.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected pixel r=%0d g=%0d b=%0d", o_red, o_green, o_blue);
                    mismatches++;
                end else begin
                    want = pixels_due.pop_front();
                    if (o_red !== want.red || o_green !== want.green || o_blue !== want.blue) begin
                        if (mismatches < MAX_REPORTS)
                            $display("pixel %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     pixels_checked, want.red, want.green, want.blue,
                                     o_red, o_green, o_blue);
                        mismatches++;
                    end
                end
                pixels_checked++;
            end
            // hold off once so the pipeline fills and back-pressures the input
            if (!hold_done && pixels_checked >= HOLD_OFF_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(0, 99) >= 19);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("complex_phase_to_rgb_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic queue_sample(int re, int im);
        t_sample s;
        s.re = 16'(re);
        s.im = 16'(im);
        samples_to_send.push_back(s);
    endtask

    task automatic queue_random(int count);
        int re, im, v;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 3))
                0: begin
                    re = int'($urandom);
                    im = int'($urandom);
                end
                1: begin
                    re = int'($urandom_range(0, 600)) - 300;
                    im = int'($urandom_range(0, 600)) - 300;
                end
                2: begin
                    re = int'($urandom_range(0, 16384)) - 8192;
                    im = int'($urandom_range(0, 16384)) - 8192;
                end
                default: begin
                    v = int'(16'($urandom));
                    case ($urandom_range(0, 3))
                        0: begin re = v; im = 0;  end
                        1: begin re = 0; im = v;  end
                        2: begin re = v; im = v;  end
                        default: begin re = v; im = -v; end
                    endcase
                end
            endcase
            queue_sample(re, im);
        end
    endtask

    task automatic wait_drained();
        while (samples_to_send.size() != 0 || i_in_valid || pixels_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_gain(logic [SCALE_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        gain_now = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, axes, zero, every sector, negative real axis wrap
        queue_sample(0, 0);
        queue_sample(32767, 0);
        queue_sample(-32768, 0);
        queue_sample(0, 32767);
        queue_sample(0, -32768);
        queue_sample(-32768, -32768);
        queue_sample(32767, 32767);
        queue_sample(-32768, 32767);
        queue_sample(32767, -32768);
        queue_sample(-1, 0);
        queue_sample(-4096, 0);
        queue_sample(1, 0);
        queue_sample(0, 1);
        queue_sample(0, -1);
        queue_sample(-1, -1);
        queue_sample(-1, 1);
        queue_sample(4096, 2365);
        queue_sample(0, 4096);
        queue_sample(-4096, 2365);
        queue_sample(-4096, -2365);
        queue_sample(0, -4096);
        queue_sample(4096, -2365);
        queue_sample(-4096, 1);
        queue_sample(-4096, -1);

        write_gain(16'd4096);
        queue_random(400);
        write_gain(16'd0);
        calm = 1'b1;
        queue_random(200);
        wait_drained();
        calm = 1'b0;
        write_gain(16'hFFFF);
        queue_random(150);
        // sender pause: let every pixel come home before carrying on
        wait_drained();
        queue_random(150);
        write_gain(16'd1);
        queue_random(150);
        write_gain(16'($urandom));
        queue_random(350);
        write_gain(16'($urandom_range(256, 8192)));
        queue_random(350);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("complex_phase_to_rgb_tb: done, clean");
        else
            $display("complex_phase_to_rgb_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cpr_pkg.sv
hw/rtl/cpr_front.sv
hw/rtl/cpr_cell.sv
hw/rtl/cpr_back.sv
hw/rtl/complex_phase_to_rgb.sv
bench/complex_phase_to_rgb_tb.sv
